FILE: rtl/ats_pkg.sv
// package for the alias table neighbour sampler
// types, constants and command/status structs; no dependencies
package ats_pkg;
	localparam int TableDepth = 4096;
	localparam int AddrW = $clog2(TableDepth);
	localparam int MaxDraws = 64;
	localparam logic [31:0] SeedReset = 32'd123456789;
	localparam logic [31:0] YReset = 32'd362436069;
	localparam logic [31:0] ZReset = 32'd521288629;
	localparam logic [31:0] WReset = 32'd88675123;
	localparam logic FuncLoad = 1'b0;
	localparam logic FuncDraw = 1'b1;

	typedef struct packed {
		logic latch_req;   // capture request fields
		logic rng_step;    // advance the generator one word
		logic cap_pick;    // start remainder from current word
		logic div_step;    // one remainder step
		logic cap_u;       // capture uniform from current word
		logic rd_entry;    // read entry at start+pick (or start+idx in copy)
		logic rd_alias;    // read value at start+alias
		logic out_load;    // load output register
		logic use_alias;   // output takes alias read
		logic next_idx;    // bump result index
	} ats_cmd_t;

	typedef struct packed {
		logic copy_mode;
		logic none;
		logic is_last;
		logic div_done;
		logic accept;      // uniform below probability
	} ats_sts_t;
endpackage

FILE: rtl/alias_table_neighbour_sampler.sv
// top level of the alias table neighbour sampler
// depends on ats_pkg, ats_ctrl, ats_datapath
//
// s_axis carries one request: tuser = func (0 load, 1 draw). tdata bits from
// low: entry_index[11:0], entry_value[43:12], entry_alias[55:44],
// entry_prob[79:56], seg_start[91:80], seg_length[104:92], out_start[128:105],
// draw_count[135:129], no fill needed at 136 bits.
// m_axis carries results: tdata = out_position[23:0], node_value[55:24],
// tlast marks the final result of a request.
// cfg_valid/cfg_ready writes the rng seed and reloads the generator.
// a load writes the tables at its handshake. a copy result needs one table
// memory read; a drawn result waits on the 32-step serial remainder plus
// generator steps and two table memory reads; up to 64 results per request.
// one request at a time.
// reset loads the generator with seed 123456789; tables are undefined until
// loaded. a stalled receiver holds the output register and the sequencer.
module alias_table_neighbour_sampler
	import ats_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// entry_index, entry_value, entry_alias, entry_prob, seg_start, seg_length,
	// out_start, draw_count
	input  logic [135:0] s_axis_tdata,
	input  logic         s_axis_tuser,  // func
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [55:0]  m_axis_tdata,  // out_position, node_value
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data
);
	ats_cmd_t cmd;
	ats_sts_t sts;
	logic load_we;
	logic [23:0] res_pos;
	logic [31:0] res_value;

	assign cfg_ready = 1'b1;
	assign m_axis_tdata = {res_value, res_pos};

	ats_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_func(s_axis_tuser), .in_ready(s_axis_tready),
		.out_ready(m_axis_tready), .out_valid(m_axis_tvalid),
		.load_we, .sts, .cmd
	);

	ats_datapath u_dp (
		.clk, .arst_n,
		.cfg_we(cfg_valid), .cfg_data,
		.load_we,
		.ld_addr(AddrW'(s_axis_tdata[11:0])),
		.ld_value(s_axis_tdata[43:12]),
		.ld_alias(s_axis_tdata[55:44]),
		.ld_prob(s_axis_tdata[79:56]),
		.rq_start(s_axis_tdata[91:80]),
		.rq_len(s_axis_tdata[104:92]),
		.rq_pos(s_axis_tdata[128:105]),
		.rq_count(s_axis_tdata[135:129]),
		.cmd, .sts,
		.res_pos, .res_value, .res_last(m_axis_tlast)
	);
endmodule

FILE: rtl/ats_datapath.sv
// datapath: table memories, xorshift128 generator, serial remainder unit
// depends on ats_pkg
module ats_datapath
	import ats_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	input  logic        load_we,
	input  logic [AddrW-1:0] ld_addr,
	input  logic [31:0] ld_value,
	input  logic [11:0] ld_alias,
	input  logic [23:0] ld_prob,
	input  logic [11:0] rq_start,
	input  logic [12:0] rq_len,
	input  logic [23:0] rq_pos,
	input  logic [6:0]  rq_count,
	input  ats_cmd_t    cmd,
	output ats_sts_t    sts,
	output logic [23:0] res_pos,
	output logic [31:0] res_value,
	output logic        res_last
);
	logic [31:0] value_mem [TableDepth];
	logic [11:0] alias_mem [TableDepth];
	logic [23:0] prob_mem [TableDepth];
	logic [31:0] x_q, y_q, z_q, w_q;
	logic [11:0] start_q;
	logic [12:0] len_q;
	logic [23:0] pos_q;
	logic [6:0]  cnt_q, idx_q;
	logic [31:0] dividend_q;
	logic [12:0] rem_q;
	logic [5:0]  bit_q;
	logic [22:0] u_q;
	logic [31:0] rd_val_q;
	logic [11:0] rd_alias_q;
	logic [23:0] rd_prob_q;
	logic [31:0] rd_alt_q;
	logic [AddrW-1:0] ent_addr, alt_addr;
	logic [31:0] t, w_next;
	logic [13:0] trial;

	// xorshift128 next word
	assign t = x_q ^ (x_q << 11);
	assign w_next = w_q ^ (w_q >> 19) ^ (t ^ (t >> 8));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= SeedReset; y_q <= YReset; z_q <= ZReset; w_q <= WReset;
		end else if (cfg_we) begin
			x_q <= cfg_data; y_q <= YReset; z_q <= ZReset; w_q <= WReset;
		end else if (cmd.rng_step) begin
			x_q <= y_q; y_q <= z_q; z_q <= w_q; w_q <= w_next;
		end
	end

	// request registers, index and saturated count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.latch_req) begin
			idx_q <= '0;
		end else if (cmd.next_idx) begin
			idx_q <= idx_q + 7'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			start_q <= rq_start;
			len_q <= rq_len;
			pos_q <= rq_pos;
			cnt_q <= (rq_count > 7'(MaxDraws)) ? 7'(MaxDraws) : rq_count;
		end
	end

	// restoring remainder, one dividend bit per cycle
	assign trial = {rem_q, dividend_q[31]};
	always_ff @(posedge clk) begin
		if (cmd.cap_pick) begin
			dividend_q <= w_q;
			rem_q <= '0;
			bit_q <= 6'd32;
		end else if (cmd.div_step) begin
			dividend_q <= {dividend_q[30:0], 1'b0};
			rem_q <= (trial >= {1'b0, len_q}) ? 13'(trial - {1'b0, len_q}) : trial[12:0];
			bit_q <= bit_q - 6'd1;
		end
		if (cmd.cap_u) u_q <= w_q[31:9];
	end

	// table addressing, wraps modulo depth
	assign ent_addr = sts.copy_mode ? AddrW'(start_q + 12'(idx_q))
		: AddrW'({1'b0, start_q} + rem_q);
	assign alt_addr = AddrW'(start_q + rd_alias_q);

	always_ff @(posedge clk) begin
		if (load_we) begin
			value_mem[ld_addr] <= ld_value;
			alias_mem[ld_addr] <= ld_alias;
			prob_mem[ld_addr] <= ld_prob;
		end
		if (cmd.rd_entry) begin
			rd_val_q <= value_mem[ent_addr];
			rd_alias_q <= alias_mem[ent_addr];
			rd_prob_q <= prob_mem[ent_addr];
		end
		if (cmd.rd_alias) rd_alt_q <= value_mem[alt_addr];
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_pos <= pos_q + 24'(idx_q);
			res_value <= cmd.use_alias ? rd_alt_q : rd_val_q;
			res_last <= sts.is_last;
		end
	end

	assign sts.copy_mode = ({6'd0, cnt_q} >= len_q);
	assign sts.none = sts.copy_mode ? (len_q == '0) : (cnt_q == '0);
	assign sts.is_last = sts.copy_mode ? (13'(idx_q) + 13'd1 == len_q)
		: (idx_q + 7'd1 == cnt_q);
	assign sts.div_done = (bit_q == '0);
	assign sts.accept = ({1'b0, u_q} < rd_prob_q);
endmodule

FILE: rtl/ats_ctrl.sv
// controller state machine sequencing loads, copies and draws
// depends on ats_pkg
module ats_ctrl
	import ats_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_func,
	output logic     in_ready,
	input  logic     out_ready,
	output logic     out_valid,
	output logic     load_we,
	input  ats_sts_t sts,
	output ats_cmd_t cmd
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_CHECK = 10'b0000000010,
		S_RNG1  = 10'b0000000100,
		S_DIV   = 10'b0000001000,
		S_RNG2  = 10'b0000010000,
		S_RDE   = 10'b0000100000,
		S_RDA   = 10'b0001000000,
		S_EMIT  = 10'b0010000000,
		S_WAIT  = 10'b0100000000,
		S_CPY   = 10'b1000000000
	} state_t;
	state_t state_q, state_d;
	logic valid_q, valid_d, last_q, last_d;

	assign in_ready = (state_q == S_IDLE) && !valid_q;
	assign out_valid = valid_q;
	assign load_we = in_valid && in_ready && (in_func == FuncLoad);

	// next state and commands
	always_comb begin
		state_d = state_q;
		valid_d = valid_q && !out_ready;
		last_d = last_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready && in_func == FuncDraw) begin
					cmd.latch_req = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.none) state_d = S_IDLE;
				else if (sts.copy_mode) state_d = S_CPY;
				else state_d = S_RNG1;
			end
			S_CPY: begin
				cmd.rd_entry = 1'b1;
				state_d = S_EMIT;
			end
			S_RNG1: begin
				cmd.rng_step = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (!sts.div_done && last_q) cmd.div_step = 1'b1;
				else if (!last_q) cmd.cap_pick = 1'b1;
				last_d = 1'b1;
				if (sts.div_done && last_q) begin
					cmd.rng_step = 1'b1;
					last_d = 1'b0;
					state_d = S_RNG2;
				end
			end
			S_RNG2: begin
				cmd.cap_u = 1'b1;
				state_d = S_RDE;
			end
			S_RDE: begin
				cmd.rd_entry = 1'b1;
				state_d = S_RDA;
			end
			S_RDA: begin
				cmd.rd_alias = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					cmd.use_alias = !sts.copy_mode && !sts.accept;
					valid_d = 1'b1;
					cmd.next_idx = 1'b1;
					if (sts.is_last) state_d = S_WAIT;
					else state_d = sts.copy_mode ? S_CPY : S_RNG1;
				end
			end
			S_WAIT: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
			last_q <= last_d;
		end
	end

`ifndef SYNTH
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready) else $error("accept while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> valid_q) else $error("result dropped");
`endif
endmodule

FILE: test/tb_top.sv
// testbench for the alias table neighbour sampler: scoreboard class with an
// xorshift128 alias-draw predictor, stream drivers and a cycle watchdog
// depends on ats_pkg and alias_table_neighbour_sampler
module tb_top;
	import ats_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdleLimit = 20000;
	localparam int HoldCycles = 2000;
	localparam int SettleCycles = 200;
	// loaded window of the table, wrapping past the top address
	localparam int WinBase = 4080;
	localparam int WinSize = 80;
	localparam int AliasSpan = 16;
	localparam int SegReach = 64;
	localparam int PhaseItems = 44;

	typedef struct packed {
		logic [23:0] pos;
		logic [31:0] val;
		logic        last;
	} sample_t;

	// tracks table contents and generator state, holds the expected samples
	class sample_board;
		logic [31:0] node_mem[TableDepth];
		logic [11:0] alias_mem[TableDepth];
		logic [23:0] prob_mem[TableDepth];
		logic [31:0] gx, gy, gz, gw;
		sample_t pending[$];
		int failures;

		function new();
			failures = 0;
			reseed(SeedReset);
		endfunction

		function void reseed(logic [31:0] seed);
			gx = seed;
			gy = YReset;
			gz = ZReset;
			gw = WReset;
		endfunction

		function logic [31:0] next_word();
			logic [31:0] t;
			t = gx ^ (gx << 11);
			gx = gy;
			gy = gz;
			gz = gw;
			gw = gw ^ (gw >> 19) ^ (t ^ (t >> 8));
			return gw;
		endfunction

		// note an accepted request and queue the samples it must produce
		function void note_request(logic func, logic [135:0] d);
			logic [11:0] idx, start, a;
			logic [12:0] len;
			logic [23:0] pos0;
			logic [6:0] cnt;
			logic [31:0] pick, u;
			sample_t s;
			idx = d[11:0];
			start = d[91:80];
			len = d[104:92];
			pos0 = d[128:105];
			cnt = d[135:129];
			if (func == FuncLoad) begin
				node_mem[idx] = d[43:12];
				alias_mem[idx] = d[55:44];
				prob_mem[idx] = d[79:56];
				return;
			end
			if (cnt > MaxDraws)
				cnt = 7'(MaxDraws);
			if (len <= cnt) begin
				for (int k = 0; k < len; k++) begin
					s.pos = 24'(pos0 + k);
					s.val = node_mem[12'(start + k)];
					s.last = (k + 1 == len);
					pending.push_back(s);
				end
			end else begin
				for (int k = 0; k < cnt; k++) begin
					pick = next_word() % {19'd0, len};
					u = next_word() >> 9;
					a = start + pick[11:0];
					s.pos = 24'(pos0 + k);
					if (u < {8'd0, prob_mem[a]})
						s.val = node_mem[a];
					else
						s.val = node_mem[12'(start + alias_mem[a])];
					s.last = (k + 1 == cnt);
					pending.push_back(s);
				end
			end
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			failures++;
		endtask

		task check_result(logic [23:0] pos, logic [31:0] val, logic last);
			sample_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected sample pos %h val %h", pos, val));
				return;
			end
			e = pending.pop_front();
			if (pos !== e.pos)
				report($sformatf("position %h, want %h", pos, e.pos));
			if (val !== e.val)
				report($sformatf("value %h, want %h at pos %h", val, e.val, e.pos));
			if (last !== e.last)
				report($sformatf("last %b, want %b at pos %h", last, e.last, e.pos));
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [55:0]  m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [31:0]  cfg_data;

	sample_board board = new();
	int idle_mode;       // 0 none, 1 sender, 2 receiver, 3 both light
	logic hold_toggle;
	int idle_count;

	alias_table_neighbour_sampler dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// monitor all handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.reseed(cfg_data);
			if (s_axis_tvalid && s_axis_tready)
				board.note_request(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				board.check_result(m_axis_tdata[23:0], m_axis_tdata[55:24], m_axis_tlast);
		end
	end

	// watchdog on cycles without any accepted transfer
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_count <= 0;
		end else if (idle_count >= IdleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

	// receiver: random stalls plus a long hold when asked
	initial begin
		logic seen;
		int hold_left;
		seen = 1'b0;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_toggle != seen) begin
				seen = hold_toggle;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready = 1'b0;
			end else if (idle_mode == 2)
				m_axis_tready = ($urandom_range(99) >= 63);
			else if (idle_mode == 3)
				m_axis_tready = ($urandom_range(99) >= 10);
			else
				m_axis_tready = 1'b1;
		end
	end

	function automatic logic [135:0] pack_req(logic [11:0] idx, logic [31:0] val,
			logic [11:0] alias_off, logic [23:0] prob, logic [11:0] start,
			logic [12:0] len, logic [23:0] pos0, logic [6:0] cnt);
		return {cnt, pos0, len, start, prob, alias_off, val, idx};
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_request(logic func, logic [135:0] d);
		int gap;
		gap = 0;
		if (idle_mode == 1 && $urandom_range(99) < 63)
			gap = $urandom_range(1, 6);
		else if (idle_mode == 3 && $urandom_range(99) < 10)
			gap = 1;
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = func;
		s_axis_tdata = d;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic load_entry(logic [11:0] idx, logic [31:0] val, logic [11:0] alias_off,
			logic [23:0] prob);
		send_request(FuncLoad, pack_req(idx, val, alias_off, prob, '0, '0, '0, '0));
	endtask

	task automatic draw_request(logic [11:0] start, logic [12:0] len, logic [23:0] pos0,
			logic [6:0] cnt);
		send_request(FuncDraw, pack_req(12'($urandom), $urandom, 12'($urandom),
			24'($urandom), start, len, pos0, cnt));
	endtask

	// wait for every expected sample, then let the sequencer settle
	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_seed(logic [31:0] seed);
		cfg_valid = 1'b1;
		cfg_data = seed;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [23:0] rand_prob();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 24'd0;
		if (r == 1)
			return 24'd8388608;
		return 24'($urandom_range(8388607));
	endfunction

	// segments and aliases of draws that read entries stay inside the loaded window
	task automatic random_request();
		int r, j0;
		logic [12:0] len;
		logic [6:0] cnt;
		if ($urandom_range(99) < 30) begin
			load_entry(12'(WinBase + $urandom_range(WinSize - 1)), $urandom,
				12'($urandom_range(AliasSpan - 1)), rand_prob());
			return;
		end
		if ($urandom_range(99) < 10) begin
			// zero count reads no entry, any segment goes
			draw_request(12'($urandom), 13'($urandom_range(0, 4096)), 24'($urandom), 7'd0);
			return;
		end
		j0 = $urandom_range(0, SegReach - 24);
		r = $urandom_range(99);
		if (r < 80)
			len = 13'($urandom_range(0, 12));
		else
			len = 13'($urandom_range(0, SegReach - j0));
		r = $urandom_range(99);
		if (r < 85)
			cnt = 7'($urandom_range(0, 10));
		else if (r < 93)
			cnt = 7'($urandom_range(0, 127));
		else
			cnt = 7'd64;
		draw_request(12'(WinBase + j0), len, 24'($urandom), cnt);
	endtask

	initial begin
		logic [31:0] seeds[4];
		seeds = '{32'h0, 32'hFFFFFFFF, 32'h0, SeedReset};
		seeds[2] = $urandom;
		arst_n = 1'b0;
		idle_mode = 0;
		hold_toggle = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = FuncLoad;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill the window so no draw reads an unwritten slot
		for (int i = 0; i < WinSize; i++)
			load_entry(12'(WinBase + i), $urandom, 12'($urandom_range(AliasSpan - 1)),
				rand_prob());

		// directed cases
		load_entry(12'd0, 32'h80000000, 12'd4095, 24'd0);
		load_entry(12'd4095, 32'h7FFFFFFF, 12'd1, 24'd8388608);
		load_entry(12'd10, 32'hFFFFFFFF, 12'd0, 24'd8388607);
		draw_request(12'd5, 13'd0, 24'd100, 7'd0);          // empty segment
		draw_request(12'd5, 13'd0, 24'd100, 7'd9);          // empty, nonzero count
		draw_request(12'd5, 13'd7, 24'd200, 7'd0);          // zero count, longer segment
		draw_request(12'd4094, 13'd4, 24'hFFFFFE, 7'd4);     // copy across both wraps
		draw_request(12'd4095, 13'd1, 24'd0, 7'd127);       // saturating count, copy
		draw_request(12'd4095, 13'd2, 24'd5, 7'd1);         // alias wraps, prob one
		draw_request(12'd0, 13'd2, 24'd6, 7'd1);            // prob zero takes alias
		load_entry(12'd0, $urandom, 12'd3, rand_prob());    // keep alias in the window
		drain();                                            // sender waits for all results
		draw_request(12'(WinBase), 13'd4096, 24'hFFFFF0, 7'd0);   // full length, zero count
		draw_request(12'(WinBase), 13'd65, 24'hFFFFF0, 7'd127);   // saturated draws
		draw_request(12'd4085, 13'd40, 24'd0, 7'd64);       // long copy across wrap
		draw_request(12'd7, 13'd3, 24'hABCDEF, 7'd2);
		drain();

		// random phases, each under its own seed and idling mode
		for (int ph = 0; ph < 4; ph++) begin
			write_seed(seeds[ph]);
			idle_mode = ph;
			for (int n = 0; n < PhaseItems; n++) begin
				if (ph == 0 && n == 10)
					hold_toggle = ~hold_toggle;
				random_request();
			end
			drain();
		end

		if (board.failures == 0 && board.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
